>>> design/wavhdr_pkg.sv
// shared types, status codes and phase encoding for the wave header parser
`timescale 1ns / 1ps

package wavhdr_pkg;

  localparam int DATA_W = 232;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_NO_RIFF   = 3'd1;
  localparam logic [2:0] STATUS_NO_WAVE   = 3'd2;
  localparam logic [2:0] STATUS_FMT_SHORT = 3'd3;
  localparam logic [2:0] STATUS_TRUNC     = 3'd4;
  localparam logic [2:0] STATUS_NO_DATA   = 3'd5;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN      = 32'd16;
  localparam logic [31:0] CD_RATE          = 32'd44100;
  localparam logic [31:0] CD_BYTES_PER_SEC = 32'd176400;
  localparam logic [31:0] RIFF_EXTRA       = 32'd8;
  localparam logic [15:0] CD_CHANNELS      = 16'd2;
  localparam logic [15:0] CD_BITS          = 16'd16;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_SKIP,
    PH_FORMAT, PH_CHAN, PH_RATE, PH_BRATE, PH_ALIGN, PH_BITS,
    PH_DONE, PH_HALT
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_in;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] file_size;
    logic [31:0] data_size;
    logic [31:0] data_offset;
    logic        cd_quality;
  } result_t;

  function automatic logic [2:0] field_len(phase_t ph);
    logic [2:0] len;
    case (ph)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_RATE, PH_BRATE: len = 3'd4;
      PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS:                             len = 3'd2;
      default:                                                           len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

>>> design/wavhdr_in_reg.sv
// input register stage for incoming header bytes
`timescale 1ns / 1ps

module wavhdr_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wavhdr_pkg::item_t  in_item,
  output logic               item_valid,
  input  logic               item_take,
  output wavhdr_pkg::item_t  item
);
  import wavhdr_pkg::*;

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> design/wavhdr_parser.sv
// header parse state and per-byte update logic
`timescale 1ns / 1ps

module wavhdr_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  wavhdr_pkg::item_t    item,
  output logic                 res_valid,
  output wavhdr_pkg::result_t  res
);
  import wavhdr_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  fbi, fbi_next;
  logic [31:0] shift, shift_next;
  logic [1:0]  kind, kind_next;
  logic [31:0] chunk_len, chunk_len_next;
  logic [31:0] skip_rem, skip_rem_next;
  logic [31:0] pos, pos_next;
  logic [31:0] riff_total, riff_total_next;
  logic [15:0] fmt_code, fmt_code_next;
  logic [15:0] chans, chans_next;
  logic [15:0] align, align_next;
  logic [15:0] bits, bits_next;
  logic [31:0] srate, srate_next;
  logic [31:0] brate, brate_next;

  logic [31:0] val;
  logic [15:0] half;
  logic [2:0]  fbi_inc;
  logic [31:0] skip_dec;
  logic [31:0] fmt_extra;
  logic [31:0] pos_inc;
  logic        cd;

  assign val       = {item.byte_in, shift[31:8]};
  assign half      = val[31:16];
  assign fbi_inc   = fbi + 3'd1;
  assign skip_dec  = skip_rem - 32'd1;
  assign fmt_extra = chunk_len - FMT_MIN_LEN;
  assign pos_inc   = pos + 32'd1;
  assign cd        = (chans == CD_CHANNELS) && (bits == CD_BITS) &&
                     (srate == CD_RATE) && (brate == CD_BYTES_PER_SEC);

  always_comb begin
    phase_next      = phase;
    fbi_next        = fbi;
    shift_next      = shift;
    kind_next       = kind;
    chunk_len_next  = chunk_len;
    skip_rem_next   = skip_rem;
    pos_next        = pos;
    riff_total_next = riff_total;
    fmt_code_next   = fmt_code;
    chans_next      = chans;
    align_next      = align;
    bits_next       = bits;
    srate_next      = srate;
    brate_next      = brate;
    res_valid       = 1'b0;
    res             = '0;
    if (step) begin
      if (item.op) begin
        if (phase != PH_DONE && phase != PH_HALT) begin
          res_valid  = 1'b1;
          res.status = (phase == PH_SKIP || (phase == PH_CID && fbi == 3'd0)) ?
                       STATUS_NO_DATA : STATUS_TRUNC;
        end
        phase_next      = PH_RIFF;
        fbi_next        = '0;
        shift_next      = '0;
        kind_next       = KIND_OTHER;
        chunk_len_next  = '0;
        skip_rem_next   = '0;
        pos_next        = '0;
        riff_total_next = '0;
        fmt_code_next   = '0;
        chans_next      = '0;
        align_next      = '0;
        bits_next       = '0;
        srate_next      = '0;
        brate_next      = '0;
      end else if (phase != PH_DONE && phase != PH_HALT) begin
        pos_next = pos_inc;
        if (phase == PH_SKIP) begin
          skip_rem_next = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_next = PH_CID;
          end
        end else begin
          shift_next = val;
          if (fbi_inc < field_len(phase)) begin
            fbi_next = fbi_inc;
          end else begin
            fbi_next = '0;
            case (phase)
              PH_RIFF: begin
                if (val != TAG_RIFF) begin
                  res_valid  = 1'b1;
                  res.status = STATUS_NO_RIFF;
                  phase_next = PH_HALT;
                end else begin
                  phase_next = PH_RSIZE;
                end
              end
              PH_RSIZE: begin
                riff_total_next = val + RIFF_EXTRA;
                phase_next      = PH_WAVE;
              end
              PH_WAVE: begin
                if (val != TAG_WAVE) begin
                  res_valid  = 1'b1;
                  res.status = STATUS_NO_WAVE;
                  phase_next = PH_HALT;
                end else begin
                  phase_next = PH_CID;
                end
              end
              PH_CID: begin
                kind_next  = (val == TAG_FMT) ? KIND_FMT :
                             (val == TAG_DATA) ? KIND_DATA : KIND_OTHER;
                phase_next = PH_CSIZE;
              end
              PH_CSIZE: begin
                chunk_len_next = val;
                if (kind == KIND_FMT) begin
                  if (val < FMT_MIN_LEN) begin
                    res_valid  = 1'b1;
                    res.status = STATUS_FMT_SHORT;
                    phase_next = PH_HALT;
                  end else begin
                    phase_next = PH_FORMAT;
                  end
                end else if (kind == KIND_DATA) begin
                  res_valid         = 1'b1;
                  res.status        = STATUS_OK;
                  res.audio_format  = fmt_code;
                  res.channel_count = chans;
                  res.sample_rate   = srate;
                  res.byte_rate     = brate;
                  res.block_align   = align;
                  res.sample_bits   = bits;
                  res.file_size     = riff_total;
                  res.data_size     = val;
                  res.data_offset   = pos_inc;
                  res.cd_quality    = cd;
                  phase_next        = PH_DONE;
                end else begin
                  skip_rem_next = val;
                  phase_next    = (val != 32'd0) ? PH_SKIP : PH_CID;
                end
              end
              PH_FORMAT: begin
                fmt_code_next = half;
                phase_next    = PH_CHAN;
              end
              PH_CHAN: begin
                chans_next = half;
                phase_next = PH_RATE;
              end
              PH_RATE: begin
                srate_next = val;
                phase_next = PH_BRATE;
              end
              PH_BRATE: begin
                brate_next = val;
                phase_next = PH_ALIGN;
              end
              PH_ALIGN: begin
                align_next = half;
                phase_next = PH_BITS;
              end
              PH_BITS: begin
                bits_next     = half;
                skip_rem_next = fmt_extra;
                phase_next    = (fmt_extra != 32'd0) ? PH_SKIP : PH_CID;
              end
              default: begin
                phase_next = PH_HALT;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RIFF;
      fbi        <= '0;
      shift      <= '0;
      kind       <= KIND_OTHER;
      chunk_len  <= '0;
      skip_rem   <= '0;
      pos        <= '0;
      riff_total <= '0;
      fmt_code   <= '0;
      chans      <= '0;
      align      <= '0;
      bits       <= '0;
      srate      <= '0;
      brate      <= '0;
    end else begin
      phase      <= phase_next;
      fbi        <= fbi_next;
      shift      <= shift_next;
      kind       <= kind_next;
      chunk_len  <= chunk_len_next;
      skip_rem   <= skip_rem_next;
      pos        <= pos_next;
      riff_total <= riff_total_next;
      fmt_code   <= fmt_code_next;
      chans      <= chans_next;
      align      <= align_next;
      bits       <= bits_next;
      srate      <= srate_next;
      brate      <= brate_next;
    end
  end

endmodule

>>> design/wavhdr_out_reg.sv
// result register holding one parse result until the receiver takes it
`timescale 1ns / 1ps

module wavhdr_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  wavhdr_pkg::result_t  load_res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wavhdr_pkg::result_t  out_res
);
  import wavhdr_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

>>> design/wav_header_chunk_parser_unit.sv
// top level of the riff wave header parser
//
// input stream: one transfer per file byte, s_axis_tuser low with the byte in
// s_axis_tdata, or s_axis_tuser high to mark end of stream, which returns the
// parser to its start state (and reports status 4 or 5 if the header was
// unfinished).
// output stream: one transfer per parse result. m_axis_tuser carries the
// status code, m_axis_tdata the header fields. an error result has all data
// fields zero. after a result, bytes are dropped until end of stream.
// path: the byte or end marker that causes a result passes the input register,
// then the result register, before the result is offered.
// throughput: one byte per cycle unless the receiver stalls; each byte is a
// single shift, compare or counter step between the input register and the result register.
// when the receiver stalls, the result register holds its result and the
// input register takes at most one more byte before s_axis_tready falls.
// reset: synchronous, clears the parse state and the valid flags of both register stages.
`timescale 1ns / 1ps

module wav_header_chunk_parser_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // byte_in
  input  logic                         s_axis_tuser,   // op
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // audio_format, channel_count, sample_rate, byte_rate, block_align,
  // sample_bits, file_size, data_size, data_offset, cd_quality, zero fill
  output logic [wavhdr_pkg::DATA_W-1:0] m_axis_tdata,
  output logic [2:0]                   m_axis_tuser    // status
);
  import wavhdr_pkg::*;

  item_t   in_item, item;
  logic    item_valid, step, free;
  logic    res_valid;
  result_t res, out_res;

  assign in_item.op      = s_axis_tuser;
  assign in_item.byte_in = s_axis_tdata;
  assign step            = item_valid && free;

  wavhdr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (step),
    .item       (item)
  );

  wavhdr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  wavhdr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_res  (res),
    .free      (free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {7'd0, out_res.cd_quality, out_res.data_offset, out_res.data_size,
                         out_res.file_size, out_res.sample_bits, out_res.block_align,
                         out_res.byte_rate, out_res.sample_rate, out_res.channel_count,
                         out_res.audio_format};

endmodule

>>> design/wavhdr_checker.sv
// port-level assertions for the wave header parser, bound to the top level
`timescale 1ns / 1ps

module wavhdr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [wavhdr_pkg::DATA_W-1:0] m_axis_tdata,
  input logic [2:0]                   m_axis_tuser
);
  import wavhdr_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // no result can appear right after reset, nothing has passed both stages
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= STATUS_NO_DATA)
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata == '0)
    else $error("error result carries nonzero fields");

  // cd flag only with two channels of 16 bits
  a_cd: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[224] |->
      m_axis_tdata[31:16] == CD_CHANNELS && m_axis_tdata[127:112] == CD_BITS)
    else $error("cd flag with wrong format fields");

endmodule

bind wav_header_chunk_parser_unit wavhdr_checker u_wavhdr_checker (.*);
